FILE: hdl/csru_pkg.sv
// ----------------------------------------------------------------------------
// csru_pkg: shared types for the count-sorted rank update block
// Item layouts for the command and result channels and the fixed field widths.
// ----------------------------------------------------------------------------
package csru_pkg;

    localparam int ENTRY_W     = 6;
    localparam int TOP_COUNT_W = 16;

    typedef struct packed {
        logic               inc_enable;
        logic [ENTRY_W-1:0] inc_entry;
        logic               dec_enable;
        logic [ENTRY_W-1:0] dec_entry;
    } cmd_item_t;

    typedef struct packed {
        logic [ENTRY_W-1:0]     inc_rank;
        logic [ENTRY_W-1:0]     dec_rank;
        logic [ENTRY_W-1:0]     top_entry;
        logic [TOP_COUNT_W-1:0] top_count;
        logic                   saturated;
    } res_item_t;

endpackage

FILE: hdl/csru_chan_if.sv
// ----------------------------------------------------------------------------
// csru_chan_if: valid/ready channel
// Carries one item per handshake; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface csru_chan_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: hdl/csru_ram.sv
// ----------------------------------------------------------------------------
// csru_ram: simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module csru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/count_sorted_rank_update.sv
// Throughput: one item at a time; each compare step reads the order memory (rank to
// entry), then the count via the single read port of the count/rank memory.
// Reset: rst_n clears control at once, then a clearing pass over every entry
// zeroes every count and loads the identity order before the first item is taken.
// ----------------------------------------------------------------------------
// count_sorted_rank_update: frequency-sorted index with incremental update
// Keeps per-entry counts, a rank order sorted by count (largest first) and the
// entry-to-rank map; each item bumps counts and bubbles the entries into place.
// ----------------------------------------------------------------------------
module count_sorted_rank_update #(
    parameter int NUM_ENTRIES = 64,
    parameter int COUNT_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    csru_chan_if.sink   cmd,
    csru_chan_if.source res
);

    localparam int IDX_W   = $clog2(NUM_ENTRIES);
    localparam int A_W     = COUNT_BITS + IDX_W;
    localparam int ENTRY_W = csru_pkg::ENTRY_W;
    localparam int TOP_W   = csru_pkg::TOP_COUNT_W;

    localparam logic [IDX_W-1:0]      LAST_RANK = IDX_W'(NUM_ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_INC_RD = 4'd2;
    localparam logic [3:0] S_INC_WR = 4'd3;
    localparam logic [3:0] S_DEC_RD = 4'd4;
    localparam logic [3:0] S_DEC_WR = 4'd5;
    localparam logic [3:0] S_P_RD   = 4'd6;
    localparam logic [3:0] S_P_GO   = 4'd7;
    localparam logic [3:0] S_P_NB   = 4'd8;
    localparam logic [3:0] S_P_CMP  = 4'd9;
    localparam logic [3:0] S_P_END  = 4'd10;
    localparam logic [3:0] S_OUT_A  = 4'd11;
    localparam logic [3:0] S_OUT_B  = 4'd12;
    localparam logic [3:0] S_OUT_C  = 4'd13;
    localparam logic [3:0] S_OUT_D  = 4'd14;

    // control
    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic             do_inc_reg, do_inc_next;
    logic             do_dec_reg, do_dec_next;
    logic             inc_ok_reg, inc_ok_next;
    logic             dec_ok_reg, dec_ok_next;
    logic             pass_up_reg, pass_up_next;
    logic             sat_reg, sat_next;
    logic             res_valid_reg, res_valid_next;

    // payload
    logic [IDX_W-1:0]      inc_addr_reg, inc_addr_next;
    logic [IDX_W-1:0]      dec_addr_reg, dec_addr_next;
    logic [COUNT_BITS-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0]      r_reg, r_next;
    logic [IDX_W-1:0]      nb_reg, nb_next;
    logic [IDX_W-1:0]      inc_rank_reg, inc_rank_next;
    logic [IDX_W-1:0]      dec_rank_reg, dec_rank_next;
    logic [IDX_W-1:0]      top_reg, top_next;
    csru_pkg::res_item_t   res_data_reg, res_data_next;

    // count/rank memory (by entry) and entry memory (by rank)
    logic                  a_we;
    logic [IDX_W-1:0]      a_waddr, a_raddr;
    logic [A_W-1:0]        a_wdata, a_rdata;
    logic                  b_we;
    logic [IDX_W-1:0]      b_waddr, b_raddr, b_wdata, b_rdata;
    logic [COUNT_BITS-1:0] a_cnt;
    logic [IDX_W-1:0]      a_rank;

    logic             in_inc_ok, in_dec_ok, in_do_inc, in_do_dec;
    logic [IDX_W-1:0] pass_addr;
    logic [IDX_W-1:0] go_nbr, cur_nbr, next_nbr;
    logic             go_edge, cur_edge, move;

    csru_ram #(
        .WIDTH (A_W),
        .DEPTH (NUM_ENTRIES)
    ) u_count_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    csru_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_ENTRIES)
    ) u_order_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    assign a_cnt  = a_rdata[A_W-1 -: COUNT_BITS];
    assign a_rank = a_rdata[IDX_W-1:0];

    assign cmd.ready = (state_reg == S_IDLE);
    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    assign in_inc_ok = (32'(cmd.data.inc_entry) < NUM_ENTRIES);
    assign in_dec_ok = (32'(cmd.data.dec_entry) < NUM_ENTRIES);
    assign in_do_inc = cmd.data.inc_enable && in_inc_ok;
    assign in_do_dec = cmd.data.dec_enable && in_dec_ok;

    assign pass_addr = pass_up_reg ? inc_addr_reg : dec_addr_reg;
    assign go_nbr    = pass_up_reg ? a_rank - 1'b1 : a_rank + 1'b1;
    assign cur_nbr   = pass_up_reg ? r_reg - 1'b1 : r_reg + 1'b1;
    assign next_nbr  = pass_up_reg ? cur_nbr - 1'b1 : cur_nbr + 1'b1;
    assign go_edge   = pass_up_reg ? (a_rank == '0) : (a_rank == LAST_RANK);
    assign cur_edge  = pass_up_reg ? (cur_nbr == '0) : (cur_nbr == LAST_RANK);
    assign move      = pass_up_reg ? (cur_reg > a_cnt) : (cur_reg < a_cnt);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        do_inc_next    = do_inc_reg;
        do_dec_next    = do_dec_reg;
        inc_ok_next    = inc_ok_reg;
        dec_ok_next    = dec_ok_reg;
        pass_up_next   = pass_up_reg;
        sat_next       = sat_reg;
        res_valid_next = res_valid_reg && !res.ready;
        inc_addr_next  = inc_addr_reg;
        dec_addr_next  = dec_addr_reg;
        cur_next       = cur_reg;
        r_next         = r_reg;
        nb_next        = nb_reg;
        inc_rank_next  = inc_rank_reg;
        dec_rank_next  = dec_rank_reg;
        top_next       = top_reg;
        res_data_next  = res_data_reg;

        a_we    = 1'b0;
        a_waddr = pass_addr;
        a_wdata = {cur_reg, r_reg};
        a_raddr = inc_addr_reg;
        b_we    = 1'b0;
        b_waddr = r_reg;
        b_wdata = pass_addr;
        b_raddr = cur_nbr;

        case (state_reg)
            S_CLEAR:
            begin
                a_we    = 1'b1;
                a_waddr = clr_reg;
                a_wdata = {{COUNT_BITS{1'b0}}, clr_reg};
                b_we    = 1'b1;
                b_waddr = clr_reg;
                b_wdata = clr_reg;
                if (clr_reg == LAST_RANK)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    inc_addr_next = IDX_W'(cmd.data.inc_entry);
                    dec_addr_next = IDX_W'(cmd.data.dec_entry);
                    inc_ok_next   = in_inc_ok;
                    dec_ok_next   = in_dec_ok;
                    do_inc_next   = in_do_inc;
                    do_dec_next   = in_do_dec;
                    pass_up_next  = in_do_inc;
                    sat_next      = 1'b0;
                    if (in_do_inc)
                    begin
                        state_next = S_INC_RD;
                    end
                    else if (in_do_dec)
                    begin
                        state_next = S_DEC_RD;
                    end
                    else
                    begin
                        state_next = S_OUT_A;
                    end
                end
            end

            S_INC_RD:
            begin
                a_raddr    = inc_addr_reg;
                state_next = S_INC_WR;
            end

            S_INC_WR:
            begin
                a_waddr = inc_addr_reg;
                a_wdata = {a_cnt + 1'b1, a_rank};
                if (a_cnt == COUNT_MAX)
                begin
                    sat_next = 1'b1;
                end
                else
                begin
                    a_we = 1'b1;
                end
                state_next = do_dec_reg ? S_DEC_RD : S_P_RD;
            end

            S_DEC_RD:
            begin
                a_raddr    = dec_addr_reg;
                state_next = S_DEC_WR;
            end

            S_DEC_WR:
            begin
                a_waddr = dec_addr_reg;
                a_wdata = {a_cnt - 1'b1, a_rank};
                if (a_cnt == '0)
                begin
                    sat_next = 1'b1;
                end
                else
                begin
                    a_we = 1'b1;
                end
                state_next = S_P_RD;
            end

            // fetch the moving entry's count and rank
            S_P_RD:
            begin
                a_raddr    = pass_addr;
                state_next = S_P_GO;
            end

            S_P_GO:
            begin
                cur_next = a_cnt;
                r_next   = a_rank;
                b_raddr  = go_nbr;
                if (go_edge)
                begin
                    if (pass_up_reg && do_dec_reg)
                    begin
                        pass_up_next = 1'b0;
                        state_next   = S_P_RD;
                    end
                    else
                    begin
                        state_next = S_OUT_A;
                    end
                end
                else
                begin
                    state_next = S_P_NB;
                end
            end

            // neighbor entry is back; fetch its count
            S_P_NB:
            begin
                nb_next    = b_rdata;
                a_raddr    = b_rdata;
                state_next = S_P_CMP;
            end

            S_P_CMP:
            begin
                b_we = 1'b1;
                a_we = 1'b1;
                if (move)
                begin
                    // neighbor takes our old rank; our own entry is written at the end
                    b_waddr = r_reg;
                    b_wdata = nb_reg;
                    a_waddr = nb_reg;
                    a_wdata = {a_cnt, r_reg};
                    r_next  = cur_nbr;
                    b_raddr = next_nbr;
                    state_next = cur_edge ? S_P_END : S_P_NB;
                end
                else if (pass_up_reg && do_dec_reg)
                begin
                    pass_up_next = 1'b0;
                    state_next   = S_P_RD;
                end
                else
                begin
                    state_next = S_OUT_A;
                end
            end

            S_P_END:
            begin
                b_we = 1'b1;
                a_we = 1'b1;
                if (pass_up_reg && do_dec_reg)
                begin
                    pass_up_next = 1'b0;
                    state_next   = S_P_RD;
                end
                else
                begin
                    state_next = S_OUT_A;
                end
            end

            S_OUT_A:
            begin
                a_raddr    = inc_addr_reg;
                b_raddr    = '0;
                state_next = S_OUT_B;
            end

            S_OUT_B:
            begin
                inc_rank_next = a_rank;
                top_next      = b_rdata;
                a_raddr       = dec_addr_reg;
                state_next    = S_OUT_C;
            end

            S_OUT_C:
            begin
                dec_rank_next = a_rank;
                a_raddr       = top_reg;
                state_next    = S_OUT_D;
            end

            // hold the top-count read until the result register is free
            S_OUT_D:
            begin
                a_raddr = top_reg;
                if (!res_valid_reg || res.ready)
                begin
                    res_data_next.inc_rank  = inc_ok_reg ? ENTRY_W'(inc_rank_reg) : '0;
                    res_data_next.dec_rank  = dec_ok_reg ? ENTRY_W'(dec_rank_reg) : '0;
                    res_data_next.top_entry = ENTRY_W'(top_reg);
                    res_data_next.top_count = TOP_W'(a_cnt);
                    res_data_next.saturated = sat_reg;
                    res_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            do_inc_reg    <= 1'b0;
            do_dec_reg    <= 1'b0;
            inc_ok_reg    <= 1'b0;
            dec_ok_reg    <= 1'b0;
            pass_up_reg   <= 1'b0;
            sat_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            do_inc_reg    <= do_inc_next;
            do_dec_reg    <= do_dec_next;
            inc_ok_reg    <= inc_ok_next;
            dec_ok_reg    <= dec_ok_next;
            pass_up_reg   <= pass_up_next;
            sat_reg       <= sat_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inc_addr_reg <= inc_addr_next;
        dec_addr_reg <= dec_addr_next;
        cur_reg      <= cur_next;
        r_reg        <= r_next;
        nb_reg       <= nb_next;
        inc_rank_reg <= inc_rank_next;
        dec_rank_reg <= dec_rank_next;
        top_reg      <= top_next;
        res_data_reg <= res_data_next;
    end

`ifndef NO_ASSERTIONS
    a_cmp_not_at_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_P_CMP) |-> (pass_up_reg ? (r_reg != '0) : (r_reg != LAST_RANK)))
        else $error("compare step started from a boundary rank");

    a_sat_needs_op: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> (do_inc_reg || do_dec_reg))
        else $error("saturation flagged with no operation enabled");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == S_OUT_D))
        else $error("result loaded outside the read-out step");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!a_we && !b_we))
        else $error("memory written while waiting for an item");

    a_order_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_P_CMP && move && !cur_edge) |-> (b_waddr != b_raddr))
        else $error("order memory read and written at the same rank");
`endif

endmodule

FILE: tb/csru_checker.sv
// ----------------------------------------------------------------------------
// csru_checker: scoreboard for the count-sorted rank update block
// Watches the command and result channels, keeps its own copy of the counts
// and the rank order, predicts one result per accepted command and compares
// every returned result field by field in arrival order.
// ----------------------------------------------------------------------------
module csru_checker #(
    parameter int NUM_ENTRIES = 64,
    parameter int COUNT_BITS  = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    csru_chan_if  cmd,
    csru_chan_if  res,
    output int    errors,
    output int    pending
);

    localparam int ENTRY_W     = csru_pkg::ENTRY_W;
    localparam int TOP_COUNT_W = csru_pkg::TOP_COUNT_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] tally [NUM_ENTRIES];
    int unsigned           entry_at [NUM_ENTRIES];
    int unsigned           rank_of [NUM_ENTRIES];
    csru_pkg::res_item_t   expected_res [$];
    int                    mismatches;
    int                    results_seen;

    initial
    begin
        mismatches   = 0;
        results_seen = 0;
    end

    task report_mismatch(input string msg);
        // keep the log short when the block is badly broken
        if (mismatches < 40)
        begin
            $display("csru_checker @%0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_seen, name, got, want));
        end
    endtask

    function void swap_ranks(input int unsigned ra, input int unsigned rb);
        int unsigned ea;
        int unsigned eb;
        ea = entry_at[ra];
        eb = entry_at[rb];
        entry_at[ra] = eb;
        entry_at[rb] = ea;
        rank_of[ea]  = rb;
        rank_of[eb]  = ra;
    endfunction

    // Apply both count changes, then the increment pass, then the decrement pass.
    function csru_pkg::res_item_t predict_ranks(input csru_pkg::cmd_item_t c);
        csru_pkg::res_item_t r;
        int unsigned         ie;
        int unsigned         de;
        int unsigned         rk;
        int unsigned         top;
        logic                inc_ok;
        logic                dec_ok;
        logic                do_inc;
        logic                do_dec;
        logic                sat;

        ie     = c.inc_entry;
        de     = c.dec_entry;
        inc_ok = ie < NUM_ENTRIES;
        dec_ok = de < NUM_ENTRIES;
        do_inc = c.inc_enable && inc_ok;
        do_dec = c.dec_enable && dec_ok;
        sat    = 1'b0;

        if (do_inc)
        begin
            if (tally[ie] == COUNT_MAX)
                sat = 1'b1;
            else
                tally[ie] = tally[ie] + 1'b1;
        end
        if (do_dec)
        begin
            if (tally[de] == '0)
                sat = 1'b1;
            else
                tally[de] = tally[de] - 1'b1;
        end

        if (do_inc)
        begin
            rk = rank_of[ie];
            while (rk > 0 && tally[entry_at[rk]] > tally[entry_at[rk-1]])
            begin
                swap_ranks(rk, rk - 1);
                rk--;
            end
        end
        if (do_dec)
        begin
            rk = rank_of[de];
            while (rk + 1 < NUM_ENTRIES && tally[entry_at[rk]] < tally[entry_at[rk+1]])
            begin
                swap_ranks(rk, rk + 1);
                rk++;
            end
        end

        top         = entry_at[0];
        r.inc_rank  = inc_ok ? ENTRY_W'(rank_of[ie]) : '0;
        r.dec_rank  = dec_ok ? ENTRY_W'(rank_of[de]) : '0;
        r.top_entry = ENTRY_W'(top);
        r.top_count = TOP_COUNT_W'(tally[top]);
        r.saturated = sat;
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        csru_pkg::res_item_t got;
        csru_pkg::res_item_t want;

        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                tally[i]    = '0;
                entry_at[i] = i;
                rank_of[i]  = i;
            end
            expected_res.delete();
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                expected_res.push_back(predict_ranks(cmd.data));
            end
            if (res.valid && res.ready)
            begin
                got = res.data;
                if (expected_res.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with no item pending",
                                              results_seen));
                end
                else
                begin
                    want = expected_res.pop_front();
                    check_field("inc_rank",  32'(got.inc_rank),  32'(want.inc_rank));
                    check_field("dec_rank",  32'(got.dec_rank),  32'(want.dec_rank));
                    check_field("top_entry", 32'(got.top_entry), 32'(want.top_entry));
                    check_field("top_count", 32'(got.top_count), 32'(want.top_count));
                    check_field("saturated", 32'(got.saturated), 32'(want.saturated));
                end
                results_seen++;
            end
        end
        pending <= expected_res.size();
        errors  <= mismatches;
    end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the count-sorted rank update block
// Drives directed commands, a long random run over a few hot entries, and a
// back-to-back burst on one entry; the checker beside the block
// predicts and compares, this module only makes traffic and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int     ENTRY_W        = csru_pkg::ENTRY_W;
    localparam int     NUM_ENTRIES    = 64;
    localparam int     COUNT_BITS     = 16;
    localparam int     CLK_PERIOD     = 4;
    localparam int     RESET_CYCLES   = 11;
    localparam int     RANDOM_ITEMS   = 1000;
    localparam int     RUSH_ITEMS     = 40;
    localparam int     TAIL_ITEMS     = 40;
    localparam int     SETTLE_CYCLES  = 40;
    localparam longint TIMEOUT_CYCLES = 8_000_000;

    typedef enum int {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PERIODIC,
        SINK_CHOKED
    } sink_mode_e;

    logic       clk;
    logic       rst_n;
    int         fail_count;
    int         results_owed;
    int         burst_left;
    int         hot_base;
    logic       rush;
    sink_mode_e sink_mode;
    int         sink_phase;

    csru_chan_if #(.payload_t(csru_pkg::cmd_item_t)) cmd_ch ();
    csru_chan_if #(.payload_t(csru_pkg::res_item_t)) res_ch ();

    count_sorted_rank_update #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .res   (res_ch.source)
    );

    csru_checker #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .res     (res_ch),
        .errors  (fail_count),
        .pending (results_owed)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Result side: pick a new stall pattern whenever the phase counter runs out.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else if (rush)
        begin
            res_ch.ready <= 1'b1;
        end
        else
        begin
            if (sink_phase == 0)
            begin
                sink_mode  = sink_mode_e'($urandom_range(SINK_OPEN, SINK_CHOKED));
                sink_phase = $urandom_range(16, 96);
            end
            else
            begin
                sink_phase--;
            end
            case (sink_mode)
                SINK_OPEN:     res_ch.ready <= 1'b1;
                SINK_RANDOM:   res_ch.ready <= ($urandom_range(0, 3) != 0);
                SINK_PERIODIC: res_ch.ready <= ((sink_phase % 5) >= 2);
                default:       res_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    function automatic csru_pkg::cmd_item_t make_cmd(input int ie_en, input int ie,
                                                     input int de_en, input int de);
        csru_pkg::cmd_item_t c;
        c.inc_enable = (ie_en != 0);
        c.inc_entry  = ENTRY_W'(ie);
        c.dec_enable = (de_en != 0);
        c.dec_entry  = ENTRY_W'(de);
        return c;
    endfunction

    // Mostly hot entries so counts grow, tie and overtake one another.
    function automatic csru_pkg::cmd_item_t random_cmd();
        csru_pkg::cmd_item_t c;
        int                  pick;
        c.inc_enable = ($urandom_range(0, 99) < 75);
        c.dec_enable = ($urandom_range(0, 99) < 50);
        if ($urandom_range(0, 9) < 6)
            c.inc_entry = ENTRY_W'(hot_base + $urandom_range(0, 7));
        else
            c.inc_entry = ENTRY_W'($urandom_range(0, NUM_ENTRIES - 1));
        pick = $urandom_range(0, 9);
        if (pick < 3)
            c.dec_entry = c.inc_entry;
        else if (pick < 6)
            c.dec_entry = ENTRY_W'(hot_base + $urandom_range(0, 7));
        else
            c.dec_entry = ENTRY_W'($urandom_range(0, NUM_ENTRIES - 1));
        return c;
    endfunction

    task send_item(input csru_pkg::cmd_item_t c);
        int gap;
        if (burst_left == 0 && !rush)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        else if (burst_left > 0)
        begin
            burst_left--;
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // Hold the command side until every result is back, then let the block settle.
    task wait_idle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    initial
    begin
        csru_pkg::cmd_item_t plan [$];
        int                  climb_entry;

        clk          = 1'b0;
        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        res_ch.ready = 1'b0;
        burst_left   = 0;
        hot_base     = 0;
        rush         = 1'b0;
        sink_mode    = SINK_OPEN;
        sink_phase   = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // nothing enabled, decrement at zero, longest climb, same entry, ties
        plan.push_back(make_cmd(0, 0, 0, 0));
        plan.push_back(make_cmd(0, 63, 0, 63));
        plan.push_back(make_cmd(0, 0, 1, 5));
        plan.push_back(make_cmd(1, 63, 0, 0));
        plan.push_back(make_cmd(1, 63, 1, 63));
        plan.push_back(make_cmd(1, 0, 1, 63));
        plan.push_back(make_cmd(1, 1, 0, 1));
        plan.push_back(make_cmd(1, 2, 0, 0));
        plan.push_back(make_cmd(1, 2, 1, 1));
        plan.push_back(make_cmd(1, 42, 1, 42));
        plan.push_back(make_cmd(1, 42, 0, 42));
        plan.push_back(make_cmd(0, 42, 1, 42));
        plan.push_back(make_cmd(1, 21, 1, 0));
        plan.push_back(make_cmd(1, 21, 1, 0));
        plan.push_back(make_cmd(1, 21, 1, 63));
        plan.push_back(make_cmd(0, 0, 1, 21));
        plan.push_back(make_cmd(1, 63, 1, 21));
        plan.push_back(make_cmd(1, 7, 1, 56));
        plan.push_back(make_cmd(0, 63, 1, 0));
        plan.push_back(make_cmd(1, 0, 1, 0));
        foreach (plan[i])
            send_item(plan[i]);
        wait_idle();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                wait_idle();
            if (i % 200 == 0)
                hot_base = $urandom_range(0, NUM_ENTRIES - 1);
            send_item(random_cmd());
        end

        // Hammer one entry with no idling on either side.
        climb_entry = hot_base;
        rush = 1'b1;
        repeat (RUSH_ITEMS)
            send_item(make_cmd(1, climb_entry, 0, 0));
        send_item(make_cmd(1, climb_entry, 1, climb_entry));
        send_item(make_cmd(1, climb_entry, 1, climb_entry));
        send_item(make_cmd(1, climb_entry, 0, climb_entry));
        send_item(make_cmd(1, climb_entry, 1, (climb_entry + 32) % NUM_ENTRIES));
        rush = 1'b0;
        burst_left = 0;

        repeat (TAIL_ITEMS)
            send_item(random_cmd());

        wait_idle();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
hdl/csru_pkg.sv
hdl/csru_chan_if.sv
hdl/csru_ram.sv
hdl/count_sorted_rank_update.sv
tb/csru_checker.sv
tb/testbench.sv
